// ----- sv/ircap_pkg.sv -----
`default_nettype none

package ircap_pkg;

  localparam int unsigned BUFFER_DEPTH = 128;
  localparam int unsigned COUNT_WIDTH  = 16;

  localparam int unsigned IDX_W    = 7;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned GAP_W    = 16;
  localparam int unsigned DCOUNT_W = 8;
  localparam int unsigned ADDR_W   = $clog2(BUFFER_DEPTH);
  localparam int unsigned SCNT_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CMP_W    = (SCNT_W > IDX_W) ? SCNT_W : IDX_W;
  localparam int unsigned GCMP_W   = (COUNT_WIDTH > GAP_W) ? COUNT_WIDTH : GAP_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_THRESHOLD = 1'b0,
    CFG_BLINK_ENABLE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_RESUME = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_MARK  = 2'd1,
    RX_SPACE = 2'd2,
    RX_STOP  = 2'd3
  } rx_mode_e;

endpackage

`default_nettype wire

// ----- sv/ircap_in_if.sv -----
`default_nettype none

interface ircap_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       mark_level;
  logic [6:0] read_index;

  modport source (output valid, output opcode, output mark_level, output read_index,
                  input ready);
  modport sink (input valid, input opcode, input mark_level, input read_index,
                output ready);
endinterface

`default_nettype wire

// ----- sv/ircap_out_if.sv -----
`default_nettype none

interface ircap_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  rx_state;
  logic [7:0]  duration_count;
  logic [15:0] read_duration;
  logic        frame_ready;
  logic        indicator_on;

  modport source (output valid, output rx_state, output duration_count,
                  output read_duration, output frame_ready, output indicator_on,
                  input ready);
  modport sink (input valid, input rx_state, input duration_count,
                input read_duration, input frame_ready, input indicator_on,
                output ready);
endinterface

`default_nettype wire

// ----- sv/ir_pulse_width_capture_core.sv -----
// A result is captured in the output register at the edge that accepts its request.
// Throughput: one request per cycle unless the output stalls; the duration store is a
// single-port-write, one-read RAM touched at most once per request; state updates on accept.
// Reset (rst_ni low, asynchronous): idle, tick and duration counts zero, indicator off,
// gap threshold 100, blink off. The duration store is not cleared; no clearing pass.
`default_nettype none

module ir_pulse_width_capture_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ircap_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ircap_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ircap_in_if.sink                               in_req_i,
  ircap_out_if.source                            out_rsp_o
);

  import ircap_pkg::*;

  // Configuration registers
  logic [GAP_W-1:0] gap_threshold_q;
  logic             blink_enable_q;

  // Receiver state held in flops; durations live in the RAM
  rx_mode_e               rx_mode_q, rx_mode_d;
  logic [COUNT_WIDTH-1:0] tick_count_q, tick_count_d;
  logic [SCNT_W-1:0]      stored_count_q, stored_count_d;
  logic                   indicator_level_q, indicator_level_d;

  // Output register
  logic                out_valid_q;
  rx_mode_e            out_state_q;
  logic [DCOUNT_W-1:0] out_count_q;
  logic                out_rd_q;
  logic                out_ind_q;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DUR_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DUR_W-1:0]  ram_rdata;

  logic                   accept;
  opcode_e                opcode;
  logic                   mark;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [GCMP_W-1:0]      tick_cmp;
  logic [GCMP_W-1:0]      gap_cmp;
  logic [CMP_W-1:0]       idx_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic                   buf_full;
  logic                   rd_hit;

  // Take a new request whenever the output slot is empty or being drained this cycle
  assign in_req_i.ready = !out_valid_q || out_rsp_o.ready;
  assign accept         = in_req_i.valid && in_req_i.ready;

  assign opcode   = opcode_e'(in_req_i.opcode);
  assign mark     = in_req_i.mark_level;
  assign tick_inc = tick_count_q + 1'b1;
  assign tick_cmp = GCMP_W'(tick_inc);
  assign gap_cmp  = GCMP_W'(gap_threshold_q);
  assign buf_full = stored_count_q >= SCNT_W'(BUFFER_DEPTH);

  // A read only reaches entries written in this frame; anything else answers zero
  assign idx_ext   = CMP_W'(in_req_i.read_index);
  assign cnt_ext   = CMP_W'(stored_count_q);
  assign rd_hit    = (opcode == OP_READ) && (idx_ext < cnt_ext);
  assign ram_re    = accept && rd_hit;
  assign ram_raddr = ADDR_W'(idx_ext);

  // Next state and duration store writes. A write lands at the accept edge, so a read
  // accepted in the next cycle already sees it; a request never both reads and writes.
  always_comb begin
    rx_mode_e eff_mode;
    rx_mode_d         = rx_mode_q;
    tick_count_d      = tick_count_q;
    stored_count_d    = stored_count_q;
    indicator_level_d = indicator_level_q;
    ram_we            = 1'b0;
    ram_waddr         = ADDR_W'(stored_count_q);
    ram_wdata         = DUR_W'(tick_inc);
    eff_mode          = buf_full ? RX_STOP : rx_mode_q;

    if (accept) begin
      case (opcode)
        OP_TICK: begin
          tick_count_d = tick_inc;
          rx_mode_d    = eff_mode;
          case (eff_mode)
            RX_IDLE: begin
              if (mark) begin
                if (tick_cmp < gap_cmp) begin
                  tick_count_d = '0;
                end else begin
                  // Restart the frame: the leading gap goes to entry zero
                  ram_we         = 1'b1;
                  ram_waddr      = '0;
                  stored_count_d = SCNT_W'(1);
                  tick_count_d   = '0;
                  rx_mode_d      = RX_MARK;
                end
              end
            end
            RX_MARK: begin
              if (!mark) begin
                ram_we         = 1'b1;
                stored_count_d = stored_count_q + 1'b1;
                tick_count_d   = '0;
                rx_mode_d      = RX_SPACE;
              end
            end
            RX_SPACE: begin
              if (mark) begin
                ram_we         = 1'b1;
                stored_count_d = stored_count_q + 1'b1;
                tick_count_d   = '0;
                rx_mode_d      = RX_MARK;
              end else if (tick_cmp > gap_cmp) begin
                rx_mode_d = RX_STOP;
              end
            end
            default: begin
              if (mark) begin
                tick_count_d = '0;
              end
            end
          endcase
          if (blink_enable_q) begin
            indicator_level_d = mark;
          end
        end
        OP_RESUME: begin
          rx_mode_d      = RX_IDLE;
          stored_count_d = '0;
        end
        default: begin
          // Reads and the unused code leave the state alone
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_threshold_q <= GAP_W'(100);
      blink_enable_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAP_THRESHOLD: gap_threshold_q <= GAP_W'(cfg_data_i);
        CFG_BLINK_ENABLE:  blink_enable_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_mode_q         <= RX_IDLE;
      tick_count_q      <= '0;
      stored_count_q    <= '0;
      indicator_level_q <= 1'b0;
    end else begin
      rx_mode_q         <= rx_mode_d;
      tick_count_q      <= tick_count_d;
      stored_count_q    <= stored_count_d;
      indicator_level_q <= indicator_level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result beside the RAM read; hold both while the output stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_state_q <= rx_mode_d;
      out_count_q <= DCOUNT_W'(stored_count_d);
      out_rd_q    <= rd_hit;
      out_ind_q   <= blink_enable_q && indicator_level_d;
    end
  end

  ircap_ram #(
    .WIDTH (DUR_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_rsp_o.valid          = out_valid_q;
  assign out_rsp_o.rx_state       = out_state_q;
  assign out_rsp_o.duration_count = out_count_q;
  assign out_rsp_o.read_duration  = out_rd_q ? ram_rdata : '0;
  assign out_rsp_o.frame_ready    = (out_state_q == RX_STOP);
  assign out_rsp_o.indicator_on   = out_ind_q;

endmodule

`default_nettype wire

// ----- sv/ircap_ram.sv -----
`default_nettype none

module ircap_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- verif/ir_pulse_width_capture_core_tb.sv -----
`default_nettype none

module ir_pulse_width_capture_core_tb;
  import ircap_pkg::*;

  // Give up well beyond the slowest legitimate run: about 600 requests,
  // each slowed by idling on both sides, plus the long receiver hold-off
  // and the drains around every register write.
  localparam int unsigned RUN_LIMIT = 100_000;
  // The result register is loaded at the edge that accepts the request; allow a
  // little slack on top of that before touching the registers or finishing.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned SQUEEZE_CYCLES = 64;
  localparam int unsigned PHASE_REQS = 75;

  typedef struct packed {
    opcode_e    op;
    logic       mark;
    logic [6:0] idx;
  } ir_req_t;

  typedef struct packed {
    rx_mode_e    rx_state;
    logic [7:0]  dur_count;
    logic [15:0] read_dur;
    logic        frame_rdy;
    logic        lamp_on;
  } ir_rsp_t;

  typedef enum bit {
    STEP_REQ,
    STEP_CFG
  } step_kind_e;

  // One line of the directed sequence: either a request, repeated reps times
  // (with the mark level flipping on every repeat when alt is set), or a
  // register write.
  typedef struct {
    step_kind_e  kind;
    opcode_e     op;
    logic        mark;
    logic [6:0]  idx;
    int unsigned reps;
    bit          alt;
    bit          typed;
    ir_rsp_t     rsp;
    cfg_idx_e    reg_sel;
    logic [15:0] reg_val;
  } plan_row_t;

  localparam ir_rsp_t NO_RSP        = '0;
  localparam ir_rsp_t RSP_IDLE_DARK = '{RX_IDLE, 8'd0, 16'd0, 1'b0, 1'b0};
  localparam ir_rsp_t RSP_IDLE_LIT  = '{RX_IDLE, 8'd0, 16'd0, 1'b0, 1'b1};

  localparam int unsigned PLAN_LEN = 26;

  // Directed sequence. Rows with a typed result are the ones that can be read
  // straight off the behaviour (reset state, unused opcode, resume, a mark
  // short of the full-scale threshold); all others are checked against the
  // predictor.
  plan_row_t plan [PLAN_LEN] = '{
    // straight after reset, then an unused opcode at the top index
    '{STEP_REQ, OP_READ,   1'b0, 7'd0,   1,     1'b0, 1'b1, RSP_IDLE_DARK, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_NONE,   1'b1, 7'd127, 1,     1'b0, 1'b1, RSP_IDLE_DARK, CFG_GAP_THRESHOLD, 16'd0},
    // short frame with a small gap, indicator on
    '{STEP_CFG, OP_NONE,   1'b0, 7'd0,   0,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd3},
    '{STEP_CFG, OP_NONE,   1'b0, 7'd0,   0,     1'b0, 1'b0, NO_RSP, CFG_BLINK_ENABLE,  16'd1},
    '{STEP_REQ, OP_TICK,   1'b0, 7'd0,   3,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_TICK,   1'b1, 7'd0,   3,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_TICK,   1'b0, 7'd0,   1,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_TICK,   1'b1, 7'd0,   1,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    // long space closes the frame, then a mark while stopped
    '{STEP_REQ, OP_TICK,   1'b0, 7'd0,   5,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_TICK,   1'b1, 7'd0,   1,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    // read back: first entry, just past the count, top index
    '{STEP_REQ, OP_READ,   1'b0, 7'd0,   1,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_READ,   1'b0, 7'd4,   1,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_READ,   1'b1, 7'd127, 1,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    // resume keeps the indicator, and a read then finds nothing stored
    '{STEP_REQ, OP_RESUME, 1'b0, 7'd0,   1,     1'b0, 1'b1, RSP_IDLE_LIT, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_READ,   1'b0, 7'd0,   1,     1'b0, 1'b1, RSP_IDLE_LIT, CFG_GAP_THRESHOLD, 16'd0},
    // zero gap, alternate every tick until the buffer overflows into stop
    '{STEP_CFG, OP_NONE,   1'b0, 7'd0,   0,     1'b0, 1'b0, NO_RSP, CFG_BLINK_ENABLE,  16'd0},
    '{STEP_CFG, OP_NONE,   1'b0, 7'd0,   0,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_TICK,   1'b1, 7'd0,   140,   1'b1, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_READ,   1'b0, 7'd127, 1,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_RESUME, 1'b0, 7'd0,   1,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    // full-scale gap: a mark well short of the threshold only restarts the
    // count, so the receiver stays idle with nothing stored
    '{STEP_CFG, OP_NONE,   1'b0, 7'd0,   0,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'hFFFF},
    '{STEP_REQ, OP_TICK,   1'b1, 7'd0,   1,     1'b0, 1'b1, RSP_IDLE_DARK, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_TICK,   1'b0, 7'd0,   5,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_TICK,   1'b1, 7'd0,   1,     1'b0, 1'b1, RSP_IDLE_DARK, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_READ,   1'b0, 7'd0,   1,     1'b0, 1'b1, RSP_IDLE_DARK, CFG_GAP_THRESHOLD, 16'd0},
    '{STEP_REQ, OP_RESUME, 1'b0, 7'd0,   1,     1'b0, 1'b0, NO_RSP, CFG_GAP_THRESHOLD, 16'd0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ircap_in_if  in_req ();
  ircap_out_if out_rsp ();

  ir_pulse_width_capture_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req),
    .out_rsp_o   (out_rsp)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Capture predictor: its own copy of the registers and of the receiver
  // state, advanced once per accepted request.
  logic [15:0] gap_thr;
  logic        blink_en;
  rx_mode_e    cap_mode;
  logic [15:0] cap_ticks;
  logic [7:0]  cap_count;
  logic [15:0] cap_store [BUFFER_DEPTH];
  logic        cap_level;

  ir_rsp_t     pending_rsp [$];
  int unsigned sent_cnt;
  int unsigned err_cnt;
  int unsigned cycles_run;
  bit          steady;       // no idling on either side while set
  bit          squeeze_req;  // ask the receiver for one long hold-off

  // Close the running duration: keep it if there is room, restart the count.
  function automatic void store_duration();
    if (cap_count < BUFFER_DEPTH) begin
      cap_store[cap_count] = cap_ticks;
      cap_count = cap_count + 8'd1;
    end
    cap_ticks = '0;
  endfunction

  function automatic ir_rsp_t capture_step(ir_req_t r);
    ir_rsp_t rsp;
    rsp.read_dur = '0;
    case (r.op)
      OP_TICK: begin
        cap_ticks = cap_ticks + 16'd1;
        // a full buffer forces stop before the level is looked at
        if (cap_count >= BUFFER_DEPTH) cap_mode = RX_STOP;
        case (cap_mode)
          RX_IDLE: begin
            if (r.mark) begin
              if (cap_ticks < gap_thr) begin
                cap_ticks = '0;
              end else begin
                // gap long enough: restart the frame with the gap as entry 0
                cap_count = '0;
                store_duration();
                cap_mode = RX_MARK;
              end
            end
          end
          RX_MARK: begin
            if (!r.mark) begin
              store_duration();
              cap_mode = RX_SPACE;
            end
          end
          RX_SPACE: begin
            if (r.mark) begin
              store_duration();
              cap_mode = RX_MARK;
            end else if (cap_ticks > gap_thr) begin
              cap_mode = RX_STOP;
            end
          end
          default: begin
            if (r.mark) cap_ticks = '0;
          end
        endcase
        if (blink_en) cap_level = r.mark;
      end
      OP_RESUME: begin
        cap_mode = RX_IDLE;
        cap_count = '0;
      end
      OP_READ: begin
        if (r.idx < cap_count) rsp.read_dur = cap_store[r.idx];
      end
      default: ;
    endcase
    rsp.rx_state  = cap_mode;
    rsp.dur_count = cap_count;
    rsp.frame_rdy = (cap_mode == RX_STOP);
    rsp.lamp_on   = blink_en & cap_level;
    return rsp;
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  // Offer one request, idling at random first; valid stays high on return so
  // that back-to-back requests need no extra edge.
  task automatic send_req(input ir_req_t r, input bit typed = 1'b0,
                          input ir_rsp_t typed_rsp = NO_RSP);
    ir_rsp_t predicted;
    while (!steady && $urandom_range(99) < 20) begin
      in_req.valid = 1'b0;
      @(negedge clk_i);
    end
    in_req.opcode     = r.op;
    in_req.mark_level = r.mark;
    in_req.read_index = r.idx;
    in_req.valid      = 1'b1;
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
    predicted = capture_step(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_ticks(input logic mark, input int unsigned len);
    ir_req_t r;
    r = '{op: OP_TICK, mark: mark, idx: 7'($urandom_range(127))};
    repeat (len) send_req(r);
  endtask

  // Drop valid and hold until every result is in and the pipeline is quiet.
  task automatic drain();
    in_req.valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e sel, input logic [15:0] val);
    drain();
    cfg_we_i    = 1'b1;
    cfg_index_i = sel;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (sel)
      CFG_GAP_THRESHOLD: gap_thr = val;
      CFG_BLINK_ENABLE:  blink_en = val[0];
      default: ;
    endcase
  endtask

  // One frame as a remote would send it: leading gap, alternating marks and
  // spaces, a closing space past the threshold, then a few reads. Now and
  // then leave out the resume, cut the gap short or run the buffer over.
  task automatic send_frame();
    ir_req_t     r;
    int unsigned lead;
    int unsigned n_dur;
    int unsigned run_len;
    int unsigned top_idx;
    bit          overflow;
    if ($urandom_range(9) != 0) begin
      r = '{op: OP_RESUME, mark: 1'($urandom_range(1)), idx: 7'($urandom_range(127))};
      send_req(r);
    end
    lead = ($urandom_range(4) == 0) ? $urandom_range(gap_thr)
                                    : gap_thr + $urandom_range(2);
    overflow = ($urandom_range(5) == 0);
    n_dur = overflow ? 130 : $urandom_range(12, 1);
    send_ticks(1'b0, lead);
    for (int unsigned k = 0; k < n_dur; k++) begin
      if (overflow) run_len = 1;
      else if (k[0] == 1'b0) run_len = $urandom_range(gap_thr + 1, 1);
      else run_len = $urandom_range((gap_thr > 1) ? gap_thr : 1, 1);
      send_ticks(~k[0], run_len);
    end
    send_ticks(1'b0, gap_thr + 2);
    repeat ($urandom_range(4, 1)) begin
      top_idx = (cap_count + 2 > 127) ? 127 : cap_count + 2;
      r = '{op: OP_READ, mark: 1'($urandom_range(1)), idx: 7'($urandom_range(top_idx))};
      send_req(r);
    end
  endtask

  // Set the registers, then mix well-formed frames with bursts of arbitrary
  // requests until the phase has offered its share.
  task automatic run_phase(input logic [15:0] gap, input logic blink, input int unsigned n);
    ir_req_t     r;
    int unsigned stop_at;
    write_reg(CFG_GAP_THRESHOLD, gap);
    write_reg(CFG_BLINK_ENABLE, {15'd0, blink});
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(4, 1)) begin
          r = '{op: opcode_e'($urandom_range(3)), mark: 1'($urandom_range(1)),
                idx: 7'($urandom_range(127))};
          send_req(r);
        end
      end else begin
        send_frame();
      end
    end
  endtask

  initial begin : stimulus
    ir_req_t r;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = CFG_GAP_THRESHOLD;
    cfg_data_i        = '0;
    in_req.valid      = 1'b0;
    in_req.opcode     = OP_TICK;
    in_req.mark_level = 1'b0;
    in_req.read_index = '0;
    gap_thr   = 16'd100;
    blink_en  = 1'b0;
    cap_mode  = RX_IDLE;
    cap_ticks = '0;
    cap_count = '0;
    cap_level = 1'b0;
    sent_cnt  = 0;
    steady      = 1'b0;
    squeeze_req = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        for (int unsigned k = 0; k < plan[i].reps; k++) begin
          r = '{op: plan[i].op, mark: plan[i].mark ^ (plan[i].alt & k[0]), idx: plan[i].idx};
          send_req(r, plan[i].typed, plan[i].rsp);
        end
      end
    end

    run_phase(16'd2, 1'b1, PHASE_REQS);
    // receiver holds off for a while here; keep offering so the block backs up
    squeeze_req = 1'b1;
    run_phase(16'd5, 1'b0, PHASE_REQS);
    steady = 1'b1;
    run_phase(16'd0, 1'b1, PHASE_REQS);
    steady = 1'b0;
    run_phase(16'($urandom_range(9, 1)), 1'($urandom_range(1)), PHASE_REQS);

    drain();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: stall at random about a fifth of the time, except while steady, and once
  // hold off for a long stretch when asked.
  initial begin : rsp_stall
    int unsigned hold_left;
    bit          squeezed;
    hold_left = 0;
    squeezed  = 1'b0;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req && !squeezed) begin
        hold_left = SQUEEZE_CYCLES;
        squeezed  = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready = 1'b0;
      end else begin
        out_rsp.ready = steady || ($urandom_range(99) >= 20);
      end
    end
  end

  // Compare every accepted result with the oldest outstanding prediction.
  always @(posedge clk_i) begin : rsp_check
    ir_rsp_t want;
    if (out_rsp.valid && out_rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none, got state %0d count %0d",
                 $time, out_rsp.rx_state, out_rsp.duration_count);
        err_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("rx_state", want.rx_state, out_rsp.rx_state);
        check_field("duration_count", want.dur_count, out_rsp.duration_count);
        check_field("read_duration", want.read_dur, out_rsp.read_duration);
        check_field("frame_ready", want.frame_rdy, out_rsp.frame_ready);
        check_field("indicator_on", want.lamp_on, out_rsp.indicator_on);
      end
    end
  end

  initial err_cnt = 0;
  initial cycles_run = 0;

  always @(posedge clk_i) begin
    cycles_run++;
    if (cycles_run == RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

`default_nettype wire
